// ===== rtl/rtgd_pkg.sv =====
// package: types, constants and codes of the run-length tile grid decoder
`timescale 1ns / 1ps

package rtgd_pkg;

    // grid geometry
    localparam int GRID_SIDE  = 128;
    localparam int GRID_TOTAL = GRID_SIDE * GRID_SIDE;
    localparam int SIDE_W     = $clog2(GRID_SIDE);
    localparam int ADDR_W     = $clog2(GRID_TOTAL);
    localparam int CNT_W      = $clog2(GRID_TOTAL + 1);

    // fixed field widths
    localparam int BYTE_W   = 8;
    localparam int TILE_W   = 14;
    localparam int STATUS_W = 2;

    // count byte threshold: above this a run starts
    localparam logic [BYTE_W-1:0] RUN_BASE = 8'd127;

    // segment status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_TOTAL = 2'd1;
    localparam logic [STATUS_W-1:0] ST_TRUNC = 2'd2;

    typedef enum logic [1:0] {
        PH_COUNT = 2'd0,
        PH_RUN   = 2'd1,
        PH_LIT   = 2'd2
    } t_phase;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              last_byte;
    } t_in_item;

    typedef struct packed {
        logic [TILE_W-1:0]   first_tile;
        logic [TILE_W-1:0]   grid_address;
        logic [BYTE_W-1:0]   tile_value;
        logic [BYTE_W-1:0]   run_length;
        logic                segment_done;
        logic [STATUS_W-1:0] segment_status;
    } t_out_item;

endpackage

// ===== rtl/rtgd_if.sv =====
// stream interfaces for the byte input and the tile result channels
`timescale 1ns / 1ps

interface rtgd_in_if;
    logic               valid;
    logic               ready;
    rtgd_pkg::t_in_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface rtgd_out_if;
    logic                valid;
    logic                ready;
    rtgd_pkg::t_out_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/rle_tile_grid_decoder.sv =====
// top level: run-length decoder that writes a square tile grid, transposed
`timescale 1ns / 1ps
// output: a result is registered and appears in the cycle after its byte transfer
// throughput: one byte per cycle; the only stall is a full output register
//   whose result is not taken in the same cycle
// reset: synchronous active-low i_rst_n clears the decode phase, counters,
//   overflow flag and the output valid; payload registers are not reset

module rle_tile_grid_decoder (
    input  logic     i_clk,
    input  logic     i_rst_n,
    rtgd_in_if.sink    i_byte,
    rtgd_out_if.source o_tile
);

    // decode state
    rtgd_pkg::t_phase                  r_phase, n_phase;
    logic [rtgd_pkg::BYTE_W-1:0]       r_remaining, n_remaining;
    logic [rtgd_pkg::BYTE_W-1:0]       r_repeat, n_repeat;
    logic [rtgd_pkg::CNT_W-1:0]        r_written, n_written;
    logic                              r_overflow, n_overflow;

    // output register
    logic                              r_out_valid;
    rtgd_pkg::t_out_item               r_out;
    rtgd_pkg::t_out_item               n_out;

    logic                              in_xfer;
    logic                              have_value;
    logic                              emit;
    logic [rtgd_pkg::BYTE_W-1:0]       want;
    logic [rtgd_pkg::BYTE_W-1:0]       kept;
    logic [rtgd_pkg::CNT_W-1:0]        room;
    logic [rtgd_pkg::ADDR_W-1:0]       first_idx;
    logic [rtgd_pkg::SIDE_W-1:0]       grid_col;
    logic [rtgd_pkg::SIDE_W-1:0]       grid_row;
    logic [rtgd_pkg::ADDR_W-1:0]       addr;
    logic [rtgd_pkg::BYTE_W-1:0]       byte_in;
    logic                              last_in;

    assign byte_in = i_byte.payload.data_byte;
    assign last_in = i_byte.payload.last_byte;

    // the output register frees up in the same cycle its result is taken
    assign i_byte.ready = !r_out_valid || o_tile.ready;
    assign in_xfer      = i_byte.valid && i_byte.ready;

    assign o_tile.valid   = r_out_valid;
    assign o_tile.payload = r_out;

    // next phase of the record parser
    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            rtgd_pkg::PH_COUNT: begin
                if (byte_in > rtgd_pkg::RUN_BASE) begin
                    n_phase = rtgd_pkg::PH_RUN;
                end else if (byte_in != '0) begin
                    n_phase = rtgd_pkg::PH_LIT;
                end
            end
            rtgd_pkg::PH_RUN: begin
                n_phase = rtgd_pkg::PH_COUNT;
            end
            rtgd_pkg::PH_LIT: begin
                // last literal of the record closes it
                if (r_remaining == rtgd_pkg::BYTE_W'(1)) begin
                    n_phase = rtgd_pkg::PH_COUNT;
                end
            end
            default: begin
                n_phase = rtgd_pkg::PH_COUNT;
            end
        endcase
    end

    // value bytes, tile accounting and result building
    always_comb begin
        n_remaining = r_remaining;
        n_repeat    = r_repeat;
        have_value  = 1'b0;
        want        = '0;

        unique case (r_phase)
            rtgd_pkg::PH_COUNT: begin
                if (byte_in > rtgd_pkg::RUN_BASE) begin
                    n_repeat = byte_in - rtgd_pkg::RUN_BASE;
                end else if (byte_in != '0) begin
                    n_remaining = byte_in;
                end
            end
            rtgd_pkg::PH_RUN: begin
                have_value = 1'b1;
                want       = r_repeat;
                n_repeat   = '0;
            end
            rtgd_pkg::PH_LIT: begin
                have_value  = 1'b1;
                want        = rtgd_pkg::BYTE_W'(1);
                n_remaining = r_remaining - rtgd_pkg::BYTE_W'(1);
            end
            default: begin
                have_value = 1'b0;
            end
        endcase

        // tiles still free in the grid; writes beyond it are dropped
        room = (r_written < rtgd_pkg::CNT_W'(rtgd_pkg::GRID_TOTAL))
             ? rtgd_pkg::CNT_W'(rtgd_pkg::GRID_TOTAL) - r_written : '0;
        kept = '0;
        if (have_value) begin
            kept = (rtgd_pkg::CNT_W'(want) <= room) ? want : room[rtgd_pkg::BYTE_W-1:0];
        end

        n_overflow = r_overflow || (kept != want);
        n_written  = r_written + rtgd_pkg::CNT_W'(kept);

        // transposed address of the first tile: column becomes the row
        first_idx = (kept != '0) ? r_written[rtgd_pkg::ADDR_W-1:0] : '0;
        grid_col  = rtgd_pkg::SIDE_W'(first_idx % rtgd_pkg::GRID_SIDE);
        grid_row  = rtgd_pkg::SIDE_W'(first_idx / rtgd_pkg::GRID_SIDE);
        addr      = rtgd_pkg::ADDR_W'(rtgd_pkg::ADDR_W'(grid_col)
                  * rtgd_pkg::ADDR_W'(rtgd_pkg::GRID_SIDE))
                  + rtgd_pkg::ADDR_W'(grid_row);

        emit = have_value || last_in;

        n_out.first_tile     = rtgd_pkg::TILE_W'(first_idx);
        n_out.grid_address   = rtgd_pkg::TILE_W'(addr);
        n_out.tile_value     = (kept != '0) ? byte_in : '0;
        n_out.run_length     = kept;
        n_out.segment_done   = last_in;
        n_out.segment_status = rtgd_pkg::ST_OK;
        if (last_in) begin
            // an unfinished record outranks a wrong tile total
            if (n_phase != rtgd_pkg::PH_COUNT) begin
                n_out.segment_status = rtgd_pkg::ST_TRUNC;
            end else if (n_written != rtgd_pkg::CNT_W'(rtgd_pkg::GRID_TOTAL) || n_overflow) begin
                n_out.segment_status = rtgd_pkg::ST_TOTAL;
            end
        end
    end

    // decode state: the segment end returns everything to its reset value
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= rtgd_pkg::PH_COUNT;
            r_remaining <= '0;
            r_repeat    <= '0;
            r_written   <= '0;
            r_overflow  <= 1'b0;
        end else if (in_xfer) begin
            if (last_in) begin
                r_phase     <= rtgd_pkg::PH_COUNT;
                r_remaining <= '0;
                r_repeat    <= '0;
                r_written   <= '0;
                r_overflow  <= 1'b0;
            end else begin
                r_phase     <= n_phase;
                r_remaining <= n_remaining;
                r_repeat    <= n_repeat;
                r_written   <= n_written;
                r_overflow  <= n_overflow;
            end
        end
    end

    // result register: loaded on a transfer that yields a result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_xfer) begin
            r_out_valid <= emit;
        end else if (o_tile.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer && emit) begin
            r_out <= n_out;
        end
    end

endmodule

// ===== verif/tb_rle_tile_grid_decoder.sv =====
// testbench: directed and random byte segments, every tile result checked
`timescale 1ns / 1ps

module tb_rle_tile_grid_decoder;
    import rtgd_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n;

    rtgd_in_if  byte_ch ();
    rtgd_out_if tile_ch ();

    rle_tile_grid_decoder u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (byte_ch),
        .o_tile  (tile_ch)
    );

    always #10 i_clk = ~i_clk;

    // bytes still to send, and results still owed by the block
    t_in_item  byte_plan[$];
    t_out_item tile_due[$];

    // decoder state as predicted from the accepted bytes
    t_phase            rx_phase;
    logic [BYTE_W-1:0] lits_due;
    logic [BYTE_W-1:0] run_due;
    int                tiles_done;
    bit                grid_overrun;

    bit byte_fire;
    int send_wait;
    int send_calm;
    int take_wait;
    int take_calm;
    int mismatches;

    task automatic clear_decoder();
        rx_phase     = PH_COUNT;
        lits_due     = '0;
        run_due      = '0;
        tiles_done   = 0;
        grid_overrun = 1'b0;
    endtask

    // one accepted byte: advance the predicted state, say whether a result follows
    task automatic decode_byte(input t_in_item it, output bit emits, output t_out_item res);
        bit                have_value;
        logic [BYTE_W-1:0] want;
        int                kept;
        int                first;
        have_value = 1'b0;
        want       = '0;
        kept       = 0;
        first      = 0;
        res        = '0;
        case (rx_phase)
            PH_RUN: begin
                have_value = 1'b1;
                want       = run_due;
                run_due    = '0;
                rx_phase   = PH_COUNT;
            end
            PH_LIT: begin
                have_value = 1'b1;
                want       = 8'd1;
                lits_due   = lits_due - 8'd1;
                if (lits_due == '0) rx_phase = PH_COUNT;
            end
            default: begin
                if (it.data_byte > RUN_BASE) begin
                    run_due  = it.data_byte - RUN_BASE;
                    rx_phase = PH_RUN;
                end else if (it.data_byte != '0) begin
                    lits_due = it.data_byte;
                    rx_phase = PH_LIT;
                end
            end
        endcase

        if (have_value) begin
            // tiles past the grid are dropped
            kept = (int'(want) <= GRID_TOTAL - tiles_done) ? int'(want)
                                                            : GRID_TOTAL - tiles_done;
            if (kept < int'(want)) grid_overrun = 1'b1;
            if (kept != 0) begin
                first           = tiles_done;
                res.first_tile  = first[TILE_W-1:0];
                res.grid_address = TILE_W'((first % GRID_SIDE) * GRID_SIDE + first / GRID_SIDE);
                res.tile_value  = it.data_byte;
                res.run_length  = kept[BYTE_W-1:0];
                tiles_done      = tiles_done + kept;
            end
        end

        emits = have_value || it.last_byte;
        if (it.last_byte) begin
            res.segment_done = 1'b1;
            if (rx_phase != PH_COUNT)
                res.segment_status = ST_TRUNC;
            else if (tiles_done != GRID_TOTAL || grid_overrun)
                res.segment_status = ST_TOTAL;
            else
                res.segment_status = ST_OK;
            clear_decoder();
        end
    endtask

    task automatic flag(input string msg);
        mismatches++;
        if (mismatches <= 10) $display("%s", msg);
    endtask

    task automatic check_field(input string field, input int want, input logic [31:0] got);
        if (got !== want)
            flag($sformatf("%s: expected %0d, got %0d", field, want, got));
    endtask

    // stimulus building
    task automatic push_byte(input logic [BYTE_W-1:0] b, input bit last);
        t_in_item it;
        it.data_byte = b;
        it.last_byte = last;
        byte_plan.insert(byte_plan.size(), it);
    endtask

    task automatic mark_last();
        byte_plan[byte_plan.size() - 1].last_byte = 1'b1;
    endtask

    task automatic push_run(input int len);
        push_byte(BYTE_W'(len + 127), 1'b0);
        push_byte(BYTE_W'($urandom_range(0, 255)), 1'b0);
    endtask

    task automatic push_literals(input int n);
        push_byte(BYTE_W'(n), 1'b0);
        for (int i = 0; i < n; i++) push_byte(BYTE_W'($urandom_range(0, 255)), 1'b0);
    endtask

    // n random records: mostly runs of 1 to 128 tiles and short literal records
    task automatic push_records(input int n);
        int r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 39);
            if (r == 0)
                push_literals(127);
            else if (r < 4)
                push_literals(0);
            else if (r < 20)
                push_run($urandom_range(1, 128));
            else
                push_literals($urandom_range(1, 6));
        end
    endtask

    // records adding up to the whole grid, mostly longest runs;
    // ending 0 exact, 1 overrun, 2 dangling count
    task automatic push_full_grid(input int ending);
        int left;
        int len;
        left = GRID_TOTAL;
        while (left > 0) begin
            if ($urandom_range(0, 31) != 0) begin
                len = ($urandom_range(0, 15) == 0) ? $urandom_range(1, 128) : 128;
                if (ending != 1 && len > left) len = left;
                push_run(len);
            end else begin
                len = $urandom_range(1, 4);
                if (ending != 1 && len > left) len = left;
                push_literals(len);
            end
            left -= len;
        end
        if (ending == 1) push_run($urandom_range(1, 128));
        if (ending == 2) push_byte(BYTE_W'($urandom_range(1, 255)), 1'b0);
        mark_last();
    endtask

    function automatic int pick_gap(inout int calm_left);
        int r;
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r == 0) begin
            calm_left = $urandom_range(20, 80);
            return 0;
        end
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // byte sender: a new transfer only once the previous one is taken
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            byte_ch.valid <= 1'b0;
        end else if (!byte_ch.valid || byte_fire) begin
            if (send_wait > 0) begin
                send_wait--;
                byte_ch.valid <= 1'b0;
            end else if (byte_plan.size() > 0) begin
                byte_ch.payload <= byte_plan.pop_front();
                byte_ch.valid   <= 1'b1;
                send_wait = pick_gap(send_calm);
            end else begin
                byte_ch.valid <= 1'b0;
            end
        end
    end

    // result receiver with random back-pressure
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            tile_ch.ready <= 1'b0;
        end else if (take_wait > 0) begin
            take_wait--;
            tile_ch.ready <= 1'b0;
        end else begin
            tile_ch.ready <= 1'b1;
            take_wait = pick_gap(take_calm);
        end
    end

    // watch both channels: predict on byte transfers, compare on result transfers
    always @(posedge i_clk) begin : watch
        bit        emits;
        t_out_item want;
        t_out_item got;
        byte_fire = i_rst_n && byte_ch.valid && byte_ch.ready;
        if (byte_fire) begin
            decode_byte(byte_ch.payload, emits, want);
            if (emits) tile_due.insert(tile_due.size(), want);
        end
        if (i_rst_n && tile_ch.valid && tile_ch.ready) begin
            got = tile_ch.payload;
            if (tile_due.size() == 0) begin
                flag($sformatf("result with nothing expected: tile %0d value %0d",
                               got.first_tile, got.tile_value));
            end else begin
                want = tile_due.pop_front();
                check_field("first_tile",     want.first_tile,     got.first_tile);
                check_field("grid_address",   want.grid_address,   got.grid_address);
                check_field("tile_value",     want.tile_value,     got.tile_value);
                check_field("run_length",     want.run_length,     got.run_length);
                check_field("segment_done",   want.segment_done,   got.segment_done);
                check_field("segment_status", want.segment_status, got.segment_status);
            end
        end
    end

    initial begin
        #20_000_000;
        $display("rle_tile_grid_decoder: mismatch");
        $finish;
    end

    initial begin
        int kind;
        i_rst_n         = 1'b0;
        byte_ch.valid   = 1'b0;
        byte_ch.payload = '0;
        tile_ch.ready   = 1'b0;
        byte_fire       = 1'b0;
        send_wait       = 0;
        send_calm       = 0;
        take_wait       = 0;
        take_calm       = 0;
        mismatches      = 0;
        clear_decoder();

        // directed: empty segment ended on a zero count byte
        push_byte(8'd0, 1'b1);
        // empty literal record, one literal of zero, run of one at full scale value
        push_byte(8'd0, 1'b0);
        push_byte(8'd1, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'd128, 1'b0);
        push_byte(8'hFF, 1'b1);
        // longest run, then literals straddling the count threshold
        push_byte(8'd255, 1'b0);
        push_byte(8'hAA, 1'b0);
        push_byte(8'd3, 1'b0);
        push_byte(8'd127, 1'b0);
        push_byte(8'd128, 1'b0);
        push_byte(8'h01, 1'b1);
        // segment ending on a run count byte: truncated
        push_byte(8'd200, 1'b1);
        // segment ending with literals still due: truncated
        push_byte(8'd5, 1'b0);
        push_byte(8'h12, 1'b0);
        push_byte(8'h34, 1'b1);
        // run of 127
        push_byte(8'd254, 1'b0);
        push_byte(8'h55, 1'b1);

        // random: a clean full grid and an overrun first, then a mix of short segments
        push_full_grid(0);
        push_full_grid(1);
        while (byte_plan.size() < 580) begin
            kind = $urandom_range(0, 19);
            if (kind < 13) begin
                push_records($urandom_range(1, 8));
                mark_last();
            end else if (kind < 16) begin
                // broken record at the end of the segment
                push_records($urandom_range(0, 4));
                if ($urandom_range(0, 1) == 0) begin
                    push_byte(BYTE_W'($urandom_range(1, 255)), 1'b1);
                end else begin
                    int n;
                    n = $urandom_range(2, 10);
                    push_byte(BYTE_W'(n), 1'b0);
                    for (int i = 1; i < n; i++) push_byte(BYTE_W'($urandom_range(0, 255)), 1'b0);
                    mark_last();
                end
            end else begin
                // raw noise, segment ends fall anywhere
                for (int i = $urandom_range(1, 12); i > 0; i--)
                    push_byte(BYTE_W'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
                mark_last();
            end
        end

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (byte_plan.size() != 0 || byte_ch.valid || tile_due.size() != 0)
            @(negedge i_clk);
        repeat (8) @(negedge i_clk);

        if (tile_due.size() != 0)
            flag($sformatf("%0d results never arrived", tile_due.size()));

        if (mismatches == 0) begin
            $display("rle_tile_grid_decoder: match");
        end else begin
            $display("rle_tile_grid_decoder: mismatch");
        end
        $finish;
    end

endmodule
